// ----- hw/rtl/gsd_pkg.sv -----
`timescale 1ns / 1ps

package gsd_pkg;

	// Field widths
	localparam int OP_W      = 2;
	localparam int NOW_W     = 32;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	// Default time width for internal timestamps
	localparam int TIME_BITS_DEF = 32;

	// Opcodes
	localparam logic [OP_W-1:0] OP_RUN    = 2'd0;
	localparam logic [OP_W-1:0] OP_DOCK   = 2'd1;
	localparam logic [OP_W-1:0] OP_REINIT = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PRES_DB  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ABS_DB   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSE_DL = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POLARITY = 2'd3;

	// Configuration reset values
	localparam logic [CFG_W-1:0] PRES_DB_RST  = 16'd20;
	localparam logic [CFG_W-1:0] ABS_DB_RST   = 16'd300;
	localparam logic [CFG_W-1:0] CLOSE_DL_RST = 16'd200;
	localparam logic             POLARITY_RST = 1'b0;

	// Sequencer phase, one-hot
	typedef enum logic [3:0] {
		PH_IDLE    = 4'b0001,
		PH_DELAY   = 4'b0010,
		PH_UPRIGHT = 4'b0100,
		PH_DOCK    = 4'b1000
	} phase_t;

	// Reported phase codes
	localparam logic [1:0] PHC_IDLE    = 2'd0;
	localparam logic [1:0] PHC_DELAY   = 2'd1;
	localparam logic [1:0] PHC_UPRIGHT = 2'd2;
	localparam logic [1:0] PHC_DOCK    = 2'd3;

	function automatic logic [1:0] phase_code(phase_t ph);
		logic [1:0] code;
		case (ph)
			PH_IDLE:    code = PHC_IDLE;
			PH_DELAY:   code = PHC_DELAY;
			PH_UPRIGHT: code = PHC_UPRIGHT;
			PH_DOCK:    code = PHC_DOCK;
			default:    code = PHC_IDLE;
		endcase
		return code;
	endfunction

endpackage

// ----- hw/rtl/gsd_if.sv -----
`timescale 1ns / 1ps

// Input item channel
interface gsd_item_if;
	logic                       valid;
	logic                       ready;
	logic [gsd_pkg::OP_W-1:0]   opcode;
	logic [gsd_pkg::NOW_W-1:0]  now_ms;
	logic                       raw_level;

	modport source (output valid, output opcode, output now_ms, output raw_level, input ready);
	modport sink   (input valid, input opcode, input now_ms, input raw_level, output ready);
endinterface

// Result channel
interface gsd_result_if;
	logic       valid;
	logic       ready;
	logic       servo_upright;
	logic       clamp_closed;
	logic [1:0] phase;
	logic       present_raw;

	modport source (output valid, output servo_upright, output clamp_closed, output phase,
		output present_raw, input ready);
	modport sink   (input valid, input servo_upright, input clamp_closed, input phase,
		input present_raw, output ready);
endinterface

// Configuration write channel
interface gsd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [gsd_pkg::CFG_IDX_W-1:0]   index;
	logic [gsd_pkg::CFG_W-1:0]       data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/gripper_sequencer_with_debounce_unit.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Fields                                              Transfer
// item      in   opcode[1:0], now_ms[31:0], raw_level                valid & ready
// result    out  servo_upright, clamp_closed, phase[1:0], present_raw valid & ready
// cfg       in   index[1:0], data[15:0]                              valid & ready
//
// One item per cycle sustained while result.ready is high; an item passes the input register, then the result register.
// Sequencer state is updated in the cycle an item moves from the input register
// to the result register, so each item sees the state left by the one before.
// arst_n clears control and sequencer state and loads config defaults.
// A stalled result holds the pipeline; the input register still takes an item when empty.
// cfg is always ready.

module gripper_sequencer_with_debounce_unit #(
	parameter int TIME_BITS = gsd_pkg::TIME_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	gsd_item_if.sink            item,
	gsd_result_if.source        result,
	gsd_cfg_if.sink             cfg
);
	import gsd_pkg::*;

	// Config registers
	logic [CFG_W-1:0] pres_db_q;
	logic [CFG_W-1:0] abs_db_q;
	logic [CFG_W-1:0] close_dl_q;
	logic             polarity_q;

	// Input stage
	logic                 valid_s1;
	logic [OP_W-1:0]      opcode_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic                 raw_s1;

	// Sequencer state
	phase_t               phase_q;
	logic                 last_level_q;
	logic [TIME_BITS-1:0] level_since_q;
	logic [TIME_BITS-1:0] close_started_q;
	logic                 servo_q;
	logic                 clamp_q;

	// Result register
	logic       res_valid_q;
	logic       res_servo_q;
	logic       res_clamp_q;
	logic [1:0] res_phase_q;
	logic       res_present_q;

	// Next state
	phase_t               phase_n;
	logic                 last_level_n;
	logic [TIME_BITS-1:0] level_since_n;
	logic [TIME_BITS-1:0] close_started_n;
	logic                 servo_n;
	logic                 clamp_n;

	logic                    adv;
	logic                    take;
	logic [TIME_BITS+31:0]   now_ext;
	logic [TIME_BITS-1:0]    since_el;
	logic [TIME_BITS-1:0]    close_el;
	logic [TIME_BITS+15:0]   pres_db_x;
	logic [TIME_BITS+15:0]   abs_db_x;
	logic [TIME_BITS+15:0]   close_dl_x;
	logic                    pres_held;
	logic                    abs_held;
	logic                    close_done;

	// Handshake
	assign adv        = !res_valid_q || result.ready;
	assign item.ready = !valid_s1 || adv;
	assign take       = item.valid && item.ready;
	assign cfg.ready  = 1'b1;

	// Timestamp fitted to the internal time width
	assign now_ext = {{TIME_BITS{1'b0}}, item.now_ms};

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pres_db_q  <= PRES_DB_RST;
			abs_db_q   <= ABS_DB_RST;
			close_dl_q <= CLOSE_DL_RST;
			polarity_q <= POLARITY_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_PRES_DB:  pres_db_q  <= cfg.data;
				REG_ABS_DB:   abs_db_q   <= cfg.data;
				REG_CLOSE_DL: close_dl_q <= cfg.data;
				REG_POLARITY: polarity_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			opcode_s1 <= item.opcode;
			now_s1    <= now_ext[TIME_BITS-1:0];
			raw_s1    <= item.raw_level;
		end
	end

	// Debounce and delay timing, using the switch record after this item's change
	assign pres_db_x  = {{TIME_BITS{1'b0}}, pres_db_q};
	assign abs_db_x   = {{TIME_BITS{1'b0}}, abs_db_q};
	assign close_dl_x = {{TIME_BITS{1'b0}}, close_dl_q};
	assign since_el   = now_s1 - level_since_n;
	assign close_el   = now_s1 - close_started_q;
	assign pres_held  = (last_level_n == polarity_q) && ({16'd0, since_el} >= pres_db_x);
	assign abs_held   = (last_level_n != polarity_q) && ({16'd0, since_el} >= abs_db_x);
	assign close_done = {16'd0, close_el} >= close_dl_x;

	// Switch tracking
	always_comb begin
		last_level_n  = last_level_q;
		level_since_n = level_since_q;
		if ((opcode_s1 == OP_RUN && raw_s1 != last_level_q) || opcode_s1 == OP_REINIT) begin
			last_level_n  = raw_s1;
			level_since_n = now_s1;
		end
	end

	// Sequencer
	always_comb begin
		phase_n         = phase_q;
		close_started_n = close_started_q;
		servo_n         = servo_q;
		clamp_n         = clamp_q;
		case (opcode_s1)
			OP_RUN: begin
				case (phase_q)
					PH_IDLE: begin
						servo_n = 1'b0;
						clamp_n = 1'b0;
						if (pres_held) begin
							clamp_n         = 1'b1;
							close_started_n = now_s1;
							phase_n         = PH_DELAY;
						end
					end
					PH_DELAY: begin
						if (abs_held) begin
							clamp_n = 1'b0;
							phase_n = PH_IDLE;
						end else if (close_done) begin
							servo_n = 1'b1;
							phase_n = PH_UPRIGHT;
						end
					end
					PH_UPRIGHT: begin
						servo_n = 1'b1;
						clamp_n = !abs_held;
						if (abs_held) begin
							phase_n = PH_IDLE;
						end
					end
					default: begin
						servo_n = 1'b1;
						clamp_n = 1'b0;
					end
				endcase
			end
			OP_DOCK: begin
				if (phase_q == PH_UPRIGHT) begin
					servo_n = 1'b1;
					clamp_n = 1'b0;
					phase_n = PH_DOCK;
				end
			end
			OP_REINIT: begin
				phase_n         = PH_IDLE;
				close_started_n = '0;
				servo_n         = 1'b0;
				clamp_n         = 1'b0;
			end
			default: ;
		endcase
	end

	// State update as an item moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			last_level_q    <= 1'b1;
			level_since_q   <= '0;
			close_started_q <= '0;
			servo_q         <= 1'b0;
			clamp_q         <= 1'b0;
		end else if (valid_s1 && adv) begin
			phase_q         <= phase_n;
			last_level_q    <= last_level_n;
			level_since_q   <= level_since_n;
			close_started_q <= close_started_n;
			servo_q         <= servo_n;
			clamp_q         <= clamp_n;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			res_servo_q   <= servo_n;
			res_clamp_q   <= clamp_n;
			res_phase_q   <= phase_code(phase_n);
			res_present_q <= (raw_s1 == polarity_q);
		end
	end

	assign result.valid         = res_valid_q;
	assign result.servo_upright = res_servo_q;
	assign result.clamp_closed  = res_clamp_q;
	assign result.phase         = res_phase_q;
	assign result.present_raw   = res_present_q;

	// Checks
	a_dock_outputs: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DOCK |-> servo_q && !clamp_q)
		else $error("dock phase must hold servo upright and clamp open");

	a_upright_outputs: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_UPRIGHT |-> servo_q && clamp_q)
		else $error("upright hold must have servo upright and clamp closed");

	a_delay_outputs: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DELAY |-> !servo_q && clamp_q)
		else $error("close delay must have servo mid and clamp closed");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |-> !item.ready)
		else $error("input register taken while its item is stalled");

	a_stall_keeps_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1)
		else $error("stalled item lost from input register");

endmodule
